FILE: src/sdd_pkg.sv
// ----------------------------------------------------------------------------
// Sparse depth densifier package
// Image and list geometry, internal word layouts, command codes and the small
// arithmetic helpers shared by the densifier logic.
// ----------------------------------------------------------------------------
package sdd_pkg;

   // Image and neighbour list geometry
   localparam int IMAGE_WIDTH  = 64;
   localparam int IMAGE_HEIGHT = 64;
   localparam int LIST_DEPTH   = 30;

   localparam int PIXELS     = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int PIX_AW     = $clog2(PIXELS);
   localparam int LIST_WORDS = PIXELS * LIST_DEPTH;
   localparam int LIST_AW    = $clog2(LIST_WORDS);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // Pixel coordinates: truncated 16-bit positions plus the radius margin
   localparam int CRD_W = 13;
   localparam logic signed [CRD_W-1:0] X_MAX = CRD_W'(IMAGE_WIDTH - 1);
   localparam logic signed [CRD_W-1:0] Y_MAX = CRD_W'(IMAGE_HEIGHT - 1);

   // Query arithmetic widths
   localparam int OFF_W  = 18;  // offset in 1/16 pixel
   localparam int SQ_W   = 34;  // sum of two squared offsets
   localparam int WGT_W  = 36;  // signed weight
   localparam int PROD_W = WGT_W + 17;
   localparam int SUM_W  = 58;  // weighted depth sum
   localparam int DIV_W  = 41;  // weight sum
   localparam int NUM_W  = 58;  // rounded numerator
   localparam int QUO_W  = 16;
   localparam int QB_W   = 4;

   // Reset values
   localparam logic [2:0]  RADIUS_RESET = 3'd6;
   localparam logic [7:0]  SCALE_RESET  = 8'd20;
   localparam logic [15:0] LFSR_RESET   = 16'h0001;
   localparam logic [15:0] LFSR_TAPS    = 16'hB400;

   // Configuration register indexes
   localparam logic CSR_RADIUS = 1'b0;
   localparam logic CSR_SCALE  = 1'b1;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   // One neighbour list entry
   typedef struct packed {
      logic [15:0]        depth;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } entry_type;

   // One pixel word: direct mark, neighbour count and direct depth
   typedef struct packed {
      logic             mark;
      logic [CNT_W-1:0] count;
      logic [15:0]      depth;
   } pix_word_type;

   // Fixed-point position to pixel index, truncating toward zero.
   function automatic logic signed [CRD_W-1:0] to_pixel(logic signed [15:0] c);
      logic [16:0] mag;
      logic [CRD_W-1:0] pix;
      mag = c[15] ? -{c[15], c} : {1'b0, c};
      pix = mag[16:4];
      return c[15] ? $signed(-pix) : $signed(pix);
   endfunction

   // One step of the Galois shift register.
   function automatic logic [15:0] lfsr_step(logic [15:0] v);
      logic [15:0] s;
      s = v >> 1;
      return v[0] ? (s ^ LFSR_TAPS) : s;
   endfunction

   // Remainder update for one more hex digit: (rem * 16 + nib) mod LIST_DEPTH.
   function automatic logic [CNT_W-1:0] mod_step(logic [CNT_W-1:0] rem,
                                                 logic [3:0] nib);
      logic [CNT_W+3:0] v;
      v = {rem, nib};
      for (int b = 3; b >= 0; b--) begin
         if (v >= (CNT_W+4)'(LIST_DEPTH << b)) begin
            v = v - (CNT_W+4)'(LIST_DEPTH << b);
         end
      end
      return v[CNT_W-1:0];
   endfunction

endpackage

FILE: src/sparse_depth_densify.sv
// ----------------------------------------------------------------------------
// Sparse depth densifier
// Scatters sparse depth samples into per-pixel neighbour lists held in block
// memory and answers pixel queries with a direct or weighted-average depth.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Content
//  req_     in         valid / stall       cmd, coord_x, coord_y, sample_depth
//  rsp_     out        valid / stall       depth_out, valid_res
//  csr_     in         valid / ready       index, wdata (radius, output_scale)
//
//  A sample visits every pixel of the clipped square once; a pixel within
//  the radius is read and then gets the entry appended to its list. For
//  each pixel whose list is full the slot is the remainder of the shift
//  register by the list depth, one hex digit a cycle, then the write.
//  A query reads the pixel word, then each list entry in turn through the
//  list memory port, read once per entry, and ends in the bit-a-cycle divider.
//  Reset and a clear command both sweep the pixel memory, one pixel a
//  cycle, with req_stall high. A finished result waits in the output
//  register while rsp_stall is high; a new item is taken meanwhile.
//
module sparse_depth_densify (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic signed [15:0]  req_coord_x,
   input  logic signed [15:0]  req_coord_y,
   input  logic [15:0]         req_sample_depth,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [23:0]         rsp_depth_out,
   output logic                rsp_valid_res,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [7:0]          csr_wdata
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_S_VISIT,
      ST_S_DATA,
      ST_S_MOD,
      ST_S_MWR,
      ST_S_OWN_RD,
      ST_S_OWN_WR,
      ST_Q_PIX,
      ST_Q_PIXD,
      ST_Q_LRD,
      ST_Q_LD1,
      ST_Q_LD2,
      ST_Q_LD3,
      ST_Q_CHK,
      ST_Q_DIV
   } state_type;

   localparam int CRD_W = sdd_pkg::CRD_W;
   localparam int CNT_W = sdd_pkg::CNT_W;

   state_type state_ff;

   // Configuration and generator state
   logic [2:0]  radius_ff;
   logic [7:0]  scale_ff;
   logic [15:0] lfsr_ff;

   // Walk registers
   logic [sdd_pkg::PIX_AW-1:0] clr_ff;
   logic signed [CRD_W-1:0]    px_ff, py_ff, sx_ff, sy_ff, y0_ff, x1_ff, y1_ff;
   sdd_pkg::entry_type         entry_ff;
   logic [CNT_W-1:0]           mod_ff, idx_ff, n_ff;
   logic [1:0]                 dig_ff;

   // Query datapath registers
   logic [sdd_pkg::SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [15:0]                       dep_ff;
   logic signed [sdd_pkg::WGT_W-1:0]  w_ff;
   logic signed [sdd_pkg::SUM_W-1:0]  sum_ff;
   logic signed [sdd_pkg::DIV_W-1:0]  div_ff;
   logic [3:0]                        quad_ff;
   logic [sdd_pkg::NUM_W-1:0]         rem_ff;
   logic [sdd_pkg::QUO_W-1:0]         quo_ff;
   logic [sdd_pkg::QB_W-1:0]          qb_ff;
   logic [15:0]                       res_depth_ff;
   logic                              res_ok_ff;

   // Output register
   logic        rsp_valid_ff;
   logic [23:0] rsp_depth_ff;
   logic        rsp_ok_ff;
   logic        rsp_load;

   // Memories
   sdd_pkg::pix_word_type pix_mem [sdd_pkg::PIXELS];
   sdd_pkg::entry_type    list_mem [sdd_pkg::LIST_WORDS];
   sdd_pkg::pix_word_type pix_rd_ff;
   sdd_pkg::entry_type    list_rd_ff;

   logic [sdd_pkg::PIX_AW-1:0]  cur_pix, pix_addr;
   logic [sdd_pkg::LIST_AW-1:0] list_base, list_raddr, list_waddr;
   logic                        pix_we, list_we;
   sdd_pkg::pix_word_type       pix_wdata;

   // Request decode
   logic signed [CRD_W-1:0] rx, ry, rad_c;
   logic                    req_on_image, req_take;

   // Sample walk helpers
   logic signed [CRD_W-1:0] dx, dy;
   logic [7:0]              d2, rad2;
   logic                    in_radius, cnt_room;
   logic signed [CRD_W-1:0] adv_px, adv_py;
   state_type               adv_state;

   // Query helpers
   logic signed [sdd_pkg::OFF_W-1:0]   ox, oy;
   logic signed [2*sdd_pkg::OFF_W-1:0] oxsq, oysq;
   logic [13:0]                        rad2q;
   logic signed [sdd_pkg::PROD_W-1:0]  prod;
   logic [sdd_pkg::NUM_W-1:0]          num, div_ext, div_sh;
   logic                              div_pos, sum_pos, rem_ge;
   logic [3:0]                         nib;

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_depth_out = rsp_depth_ff;
   assign rsp_valid_res = rsp_ok_ff;
   assign req_take      = req_valid && !req_stall;

   // Pixel index of the incoming coordinates and its image check
   always_comb begin
      rx    = sdd_pkg::to_pixel(req_coord_x);
      ry    = sdd_pkg::to_pixel(req_coord_y);
      rad_c = $signed({{(CRD_W-3){1'b0}}, radius_ff});
      req_on_image = (rx >= 0) && (rx <= sdd_pkg::X_MAX) &&
                     (ry >= 0) && (ry <= sdd_pkg::Y_MAX);
   end

   // Memory addressing
   always_comb begin
      cur_pix = sdd_pkg::PIX_AW'($unsigned(py_ff)) *
                sdd_pkg::PIX_AW'(sdd_pkg::IMAGE_WIDTH) +
                sdd_pkg::PIX_AW'($unsigned(px_ff));
      pix_addr   = (state_ff == ST_CLEAR) ? clr_ff : cur_pix;
      list_base  = sdd_pkg::LIST_AW'(cur_pix) * sdd_pkg::LIST_AW'(sdd_pkg::LIST_DEPTH);
      list_raddr = list_base + sdd_pkg::LIST_AW'(idx_ff);
   end

   // Distance test for the pixel being visited by a sample
   always_comb begin
      dx        = sx_ff - px_ff;
      dy        = sy_ff - py_ff;
      d2        = 8'($unsigned(dx * dx)) + 8'($unsigned(dy * dy));
      rad2      = 8'(radius_ff) * 8'(radius_ff);
      in_radius = (d2 <= rad2);
      cnt_room  = (pix_rd_ff.count < CNT_W'(sdd_pkg::LIST_DEPTH));
      nib       = lfsr_ff[{~dig_ff, 2'b00} +: 4];
   end

   // Step to the next pixel of the square: column outer, row inner
   always_comb begin
      adv_px    = px_ff;
      adv_py    = py_ff + 1'b1;
      adv_state = ST_S_VISIT;
      if (py_ff == y1_ff) begin
         adv_py = y0_ff;
         if (px_ff == x1_ff) begin
            adv_px    = sx_ff;
            adv_py    = sy_ff;
            adv_state = ST_S_OWN_RD;
         end else begin
            adv_px = px_ff + 1'b1;
         end
      end
   end

   // Memory write control
   always_comb begin
      pix_we     = 1'b0;
      pix_wdata  = pix_rd_ff;
      list_we    = 1'b0;
      list_waddr = list_base + sdd_pkg::LIST_AW'(pix_rd_ff.count);
      case (state_ff)
         ST_CLEAR: begin
            pix_we    = 1'b1;
            pix_wdata = '0;
         end
         ST_S_DATA: begin
            if (cnt_room) begin
               list_we         = 1'b1;
               pix_we          = 1'b1;
               pix_wdata.count = pix_rd_ff.count + 1'b1;
            end
         end
         ST_S_MWR: begin
            list_we    = 1'b1;
            list_waddr = list_base + sdd_pkg::LIST_AW'(mod_ff);
         end
         ST_S_OWN_WR: begin
            pix_we          = 1'b1;
            pix_wdata.mark  = 1'b1;
            pix_wdata.depth = entry_ff.depth;
         end
         default: begin
            pix_we = 1'b0;
         end
      endcase
   end

   // Pixel memory
   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[pix_addr] <= pix_wdata;
      end
      pix_rd_ff <= pix_mem[pix_addr];
   end

   // Neighbour list memory
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_waddr] <= entry_ff;
      end
      list_rd_ff <= list_mem[list_raddr];
   end

   // Query datapath terms
   always_comb begin
      ox   = sdd_pkg::OFF_W'(list_rd_ff.x) - (sdd_pkg::OFF_W'(px_ff) <<< 4);
      oy   = sdd_pkg::OFF_W'(list_rd_ff.y) - (sdd_pkg::OFF_W'(py_ff) <<< 4);
      oxsq = ox * ox;
      oysq = oy * oy;
      rad2q = {rad2[5:0], 8'd0};
      prod = w_ff * $signed({1'b0, dep_ff});
      div_pos = !div_ff[sdd_pkg::DIV_W-1] && (div_ff != '0);
      sum_pos = !sum_ff[sdd_pkg::SUM_W-1] && (sum_ff != '0);
      div_ext = sdd_pkg::NUM_W'($unsigned(div_ff));
      num     = sdd_pkg::NUM_W'($unsigned(sum_ff)) + (div_ext >> 1);
      div_sh  = div_ext << qb_ff;
      rem_ge  = (rem_ff >= div_sh);
      rsp_load = (state_ff == ST_Q_DIV) && (n_ff == '0) &&
                 (!rsp_valid_ff || !rsp_stall);
   end

   // Sequencer, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         radius_ff    <= sdd_pkg::RADIUS_RESET;
         scale_ff     <= sdd_pkg::SCALE_RESET;
         lfsr_ff      <= sdd_pkg::LFSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Configuration writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sdd_pkg::CSR_RADIUS: radius_ff <= csr_wdata[2:0];
               sdd_pkg::CSR_SCALE:  scale_ff  <= csr_wdata;
               default:             scale_ff  <= scale_ff;
            endcase
         end

         // A new result is loaded, or the held one leaves on a transfer
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               if (clr_ff == sdd_pkg::PIX_AW'(sdd_pkg::PIXELS - 1)) begin
                  clr_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  clr_ff <= clr_ff + 1'b1;
               end
            end

            ST_IDLE: begin
               if (req_take) begin
                  case (sdd_pkg::cmd_type'(req_cmd))
                     sdd_pkg::CMD_CLEAR: begin
                        state_ff <= ST_CLEAR;
                     end
                     sdd_pkg::CMD_SAMPLE: begin
                        sx_ff    <= rx;
                        sy_ff    <= ry;
                        px_ff    <= (rx - rad_c < 0) ? '0 : rx - rad_c;
                        py_ff    <= (ry - rad_c < 0) ? '0 : ry - rad_c;
                        y0_ff    <= (ry - rad_c < 0) ? '0 : ry - rad_c;
                        x1_ff    <= (rx + rad_c > sdd_pkg::X_MAX) ? sdd_pkg::X_MAX
                                                                  : rx + rad_c;
                        y1_ff    <= (ry + rad_c > sdd_pkg::Y_MAX) ? sdd_pkg::Y_MAX
                                                                  : ry + rad_c;
                        entry_ff <= {req_sample_depth, req_coord_y, req_coord_x};
                        if (req_on_image) begin
                           state_ff <= ST_S_VISIT;
                        end
                     end
                     sdd_pkg::CMD_QUERY: begin
                        px_ff        <= rx;
                        py_ff        <= ry;
                        res_ok_ff    <= 1'b0;
                        res_depth_ff <= '0;
                        state_ff     <= req_on_image ? ST_Q_PIX : ST_Q_CHK;
                        quad_ff      <= '0;
                        div_ff       <= '0;
                        n_ff         <= '0;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end

            // Sample: visit each pixel of the clipped square
            ST_S_VISIT: begin
               if (in_radius) begin
                  state_ff <= ST_S_DATA;
               end else begin
                  px_ff    <= adv_px;
                  py_ff    <= adv_py;
                  state_ff <= adv_state;
               end
            end

            ST_S_DATA: begin
               if (cnt_room) begin
                  px_ff    <= adv_px;
                  py_ff    <= adv_py;
                  state_ff <= adv_state;
               end else begin
                  lfsr_ff  <= sdd_pkg::lfsr_step(lfsr_ff);
                  mod_ff   <= '0;
                  dig_ff   <= '0;
                  state_ff <= ST_S_MOD;
               end
            end

            // Replacement slot: remainder taken one hex digit a cycle
            ST_S_MOD: begin
               mod_ff <= sdd_pkg::mod_step(mod_ff, nib);
               dig_ff <= dig_ff + 1'b1;
               if (dig_ff == 2'd3) begin
                  state_ff <= ST_S_MWR;
               end
            end

            ST_S_MWR: begin
               px_ff    <= adv_px;
               py_ff    <= adv_py;
               state_ff <= adv_state;
            end

            ST_S_OWN_RD: begin
               state_ff <= ST_S_OWN_WR;
            end

            ST_S_OWN_WR: begin
               state_ff <= ST_IDLE;
            end

            // Query: pixel word first
            ST_Q_PIX: begin
               state_ff <= ST_Q_PIXD;
            end

            // A marked pixel answers directly and skips the list
            ST_Q_PIXD: begin
               idx_ff <= '0;
               n_ff   <= pix_rd_ff.mark ? '0 : pix_rd_ff.count;
               sum_ff <= '0;
               if (pix_rd_ff.mark) begin
                  res_ok_ff    <= 1'b1;
                  res_depth_ff <= pix_rd_ff.depth;
                  quad_ff      <= 4'hF;
                  state_ff     <= ST_Q_CHK;
               end else if (pix_rd_ff.count == '0) begin
                  state_ff <= ST_Q_CHK;
               end else begin
                  state_ff <= ST_Q_LRD;
               end
            end

            // Query: each list entry in turn through ST_Q_LRD, ST_Q_LD1, ST_Q_LD2 and ST_Q_LD3
            ST_Q_LRD: begin
               state_ff <= ST_Q_LD1;
            end

            ST_Q_LD1: begin
               sqx_ff <= sdd_pkg::SQ_W'($unsigned(oxsq));
               sqy_ff <= sdd_pkg::SQ_W'($unsigned(oysq));
               dep_ff <= list_rd_ff.depth;
               quad_ff[{ox[sdd_pkg::OFF_W-1], oy[sdd_pkg::OFF_W-1]}] <= 1'b1;
               state_ff <= ST_Q_LD2;
            end

            ST_Q_LD2: begin
               w_ff <= $signed(sdd_pkg::WGT_W'(rad2q)) -
                       $signed(sdd_pkg::WGT_W'(sqx_ff + sqy_ff));
               state_ff <= ST_Q_LD3;
            end

            ST_Q_LD3: begin
               sum_ff <= sum_ff + sdd_pkg::SUM_W'(prod);
               div_ff <= div_ff + sdd_pkg::DIV_W'(w_ff);
               idx_ff <= idx_ff + 1'b1;
               state_ff <= (CNT_W'(idx_ff + 1'b1) == n_ff) ? ST_Q_CHK : ST_Q_LRD;
            end

            // Query: validity, rounding and saturation ahead of the divider
            ST_Q_CHK: begin
               if (n_ff == '0) begin
                  // Direct depth, empty list or off-image: result is ready
                  state_ff <= ST_Q_DIV;
                  qb_ff    <= '0;
                  rem_ff   <= '0;
               end else if (quad_ff != 4'hF || !div_pos) begin
                  res_ok_ff    <= 1'b0;
                  res_depth_ff <= '0;
                  n_ff         <= '0;
                  state_ff     <= ST_Q_CHK;
               end else if (!sum_pos) begin
                  res_ok_ff    <= 1'b1;
                  res_depth_ff <= '0;
                  n_ff         <= '0;
                  state_ff     <= ST_Q_CHK;
               end else if (num >= (div_ext << sdd_pkg::QUO_W)) begin
                  res_ok_ff    <= 1'b1;
                  res_depth_ff <= '1;
                  n_ff         <= '0;
                  state_ff     <= ST_Q_CHK;
               end else begin
                  rem_ff   <= num;
                  quo_ff   <= '0;
                  qb_ff    <= sdd_pkg::QB_W'(sdd_pkg::QUO_W - 1);
                  state_ff <= ST_Q_DIV;
                  n_ff     <= '1;
               end
            end

            // Restoring divider, one quotient bit a cycle; with an empty
            // list count this state only hands the result over
            ST_Q_DIV: begin
               if (n_ff == '0) begin
                  if (rsp_load) begin
                     rsp_ok_ff    <= res_ok_ff;
                     rsp_depth_ff <= 24'(res_depth_ff) * 24'(scale_ff);
                     state_ff     <= ST_IDLE;
                  end
               end else begin
                  if (rem_ge) begin
                     rem_ff <= rem_ff - div_sh;
                  end
                  quo_ff <= {quo_ff[sdd_pkg::QUO_W-2:0], rem_ge};
                  qb_ff  <= qb_ff - 1'b1;
                  if (qb_ff == '0) begin
                     res_ok_ff    <= 1'b1;
                     res_depth_ff <= {quo_ff[sdd_pkg::QUO_W-2:0], rem_ge};
                     n_ff         <= '0;
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Sparse depth densifier testbench
// Drives clear, sample, query and unused commands into the densifier, keeps a
// behavioural copy of the pixel and neighbour list state to predict each query
// result, and checks every result transfer in order against that prediction.
// The run covers several radius and scale settings and several idling phases.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 5000;
   localparam int CYCLE_LIMIT   = 8000000;
   localparam int PIXELS        = sdd_pkg::PIXELS;
   localparam int LIST_DEPTH    = sdd_pkg::LIST_DEPTH;
   localparam int IMAGE_WIDTH   = sdd_pkg::IMAGE_WIDTH;
   localparam int IMAGE_HEIGHT  = sdd_pkg::IMAGE_HEIGHT;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = sdd_pkg::CMD_CLEAR;
   logic signed [15:0] req_coord_x = '0;
   logic signed [15:0] req_coord_y = '0;
   logic [15:0] req_sample_depth = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [23:0] rsp_depth_out;
   logic        rsp_valid_res;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = sdd_pkg::CSR_RADIUS;
   logic [7:0]  csr_wdata = '0;

   sparse_depth_densify u_dut (.*);

   always #2 clock = ~clock;

   // Predicted densifier state
   sdd_pkg::entry_type nb_list [PIXELS*LIST_DEPTH];
   logic [4:0]  nb_count [PIXELS];
   logic [15:0] px_depth [PIXELS];
   logic        px_mark [PIXELS];
   logic [15:0] slot_lfsr;
   logic [2:0]  cur_radius;
   logic [7:0]  cur_scale;

   // Expected query results, oldest first
   typedef struct packed {
      logic [23:0] depth;
      logic        valid;
   } depth_result_type;
   depth_result_type depth_results [$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;

   task automatic report(input string what);
      $display("tb: mismatch: %s", what);
      errors++;
   endtask

   function automatic int pixel_of(input logic signed [15:0] c);
      int v;
      v = c;
      return v >= 0 ? (v >>> 4) : -((-v) >>> 4);
   endfunction

   function automatic void clear_frame();
      for (int i = 0; i < PIXELS; i++) begin
         nb_count[i] = '0;
         px_mark[i]  = 1'b0;
      end
   endfunction

   // Scatter one sample into the lists of every pixel within the radius.
   function automatic void scatter_sample(input logic signed [15:0] cx,
                                          input logic signed [15:0] cy,
                                          input logic [15:0] d);
      int sx, sy, r, pix, slot;
      sdd_pkg::entry_type e;
      sx = pixel_of(cx);
      sy = pixel_of(cy);
      r  = cur_radius;
      if (sx < 0 || sx >= IMAGE_WIDTH || sy < 0 || sy >= IMAGE_HEIGHT) return;
      e.x = cx;
      e.y = cy;
      e.depth = d;
      for (int px = sx - r; px <= sx + r; px++) begin
         for (int py = sy - r; py <= sy + r; py++) begin
            if (px < 0 || px >= IMAGE_WIDTH || py < 0 || py >= IMAGE_HEIGHT) continue;
            if ((sx-px)*(sx-px) + (sy-py)*(sy-py) > r*r) continue;
            pix = py * IMAGE_WIDTH + px;
            if (nb_count[pix] < LIST_DEPTH) begin
               slot = nb_count[pix];
               nb_count[pix]++;
            end else begin
               slot_lfsr = slot_lfsr[0] ? ((slot_lfsr >> 1) ^ sdd_pkg::LFSR_TAPS)
                                        : (slot_lfsr >> 1);
               slot = slot_lfsr % LIST_DEPTH;
            end
            nb_list[pix*LIST_DEPTH + slot] = e;
         end
      end
      px_depth[sy*IMAGE_WIDTH + sx] = d;
      px_mark[sy*IMAGE_WIDTH + sx]  = 1'b1;
   endfunction

   // Direct depth or weighted neighbour average of one pixel, scaled.
   function automatic depth_result_type query_depth(input logic signed [15:0] cx,
                                                    input logic signed [15:0] cy);
      int px, py, pix, n;
      longint sum, wsum, r2, ox, oy, w, avg;
      int quad [4];
      depth_result_type res;
      res = '0;
      px = pixel_of(cx);
      py = pixel_of(cy);
      if (px < 0 || px >= IMAGE_WIDTH || py < 0 || py >= IMAGE_HEIGHT) return res;
      pix = py * IMAGE_WIDTH + px;
      if (px_mark[pix]) begin
         avg = px_depth[pix];
      end else begin
         n = nb_count[pix];
         if (n == 0) return res;
         sum = 0;
         wsum = 0;
         r2 = longint'(cur_radius) * cur_radius * 256;
         quad = '{0, 0, 0, 0};
         for (int i = 0; i < n; i++) begin
            ox = longint'(nb_list[pix*LIST_DEPTH + i].x) - px * 16;
            oy = longint'(nb_list[pix*LIST_DEPTH + i].y) - py * 16;
            w  = r2 - (ox*ox + oy*oy);
            quad[(ox < 0 ? 2 : 0) + (oy < 0 ? 1 : 0)]++;
            sum  += w * longint'(nb_list[pix*LIST_DEPTH + i].depth);
            wsum += w;
         end
         if (quad[0] == 0 || quad[1] == 0 || quad[2] == 0 || quad[3] == 0) return res;
         if (wsum <= 0) return res;
         if (sum <= 0) avg = 0;
         else begin
            avg = (sum + wsum / 2) / wsum;
            if (avg > 65535) avg = 65535;
         end
      end
      res.depth = 24'(avg * cur_scale);
      res.valid = 1'b1;
      return res;
   endfunction

   // Send one item and predict its effect once the transfer has happened.
   task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] cx,
                            input logic signed [15:0] cy, input logic [15:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_coord_x <= cx;
      req_coord_y <= cy;
      req_sample_depth <= d;
      do @(posedge clock); while (req_stall);
      case (cmd)
         sdd_pkg::CMD_CLEAR:  clear_frame();
         sdd_pkg::CMD_SAMPLE: scatter_sample(cx, cy, d);
         sdd_pkg::CMD_QUERY:  depth_results.push_back(query_depth(cx, cy));
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (depth_results.size() != 0) @(posedge clock);
   endtask

   // Register write once the block has gone quiet.
   task automatic write_csr(input logic idx, input logic [7:0] data);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == sdd_pkg::CSR_RADIUS) cur_radius = data[2:0];
      else cur_scale = data;
   endtask

   // Position within a small window, random fraction.
   function automatic logic signed [15:0] near_coord(input int base, input int span);
      return 16'(((base + $urandom_range(span)) << 4) | $urandom_range(15));
   endfunction

   // Mostly samples and queries clustered in a window; some noise.
   task automatic random_items(input int count);
      int bx, by, kind;
      bx = $urandom_range(IMAGE_WIDTH - 16);
      by = $urandom_range(IMAGE_HEIGHT - 16);
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(999);
         if (kind < 3)
            send_item(sdd_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
         else if (kind < 20)
            send_item(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
         else if (kind < 60)
            send_item(2'($urandom_range(1, 2)), 16'($urandom), 16'($urandom),
                      16'($urandom));
         else if (kind < 80)
            send_item(2'($urandom_range(1, 2)), 16'(-$urandom_range(15)),
                      near_coord(by, 15), 16'($urandom));
         else if (kind < 560)
            send_item(sdd_pkg::CMD_SAMPLE, near_coord(bx, 15), near_coord(by, 15),
                      16'($urandom));
         else
            send_item(sdd_pkg::CMD_QUERY, near_coord(bx, 15), near_coord(by, 15),
                      16'($urandom));
      end
   endtask

   // Edges of the fields, direct and averaged depths, unused command, clear.
   task automatic test_directed();
      send_item(sdd_pkg::CMD_QUERY, 16'sh7FFF, 16'sh7FFF, '0);
      send_item(sdd_pkg::CMD_QUERY, -16'sd32768, 16'sd0, '0);
      send_item(sdd_pkg::CMD_QUERY, 16'sd100, 16'sd100, '0);
      send_item(sdd_pkg::CMD_SAMPLE, -16'sd32768, -16'sd32768, 16'hFFFF);
      send_item(sdd_pkg::CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
      send_item(sdd_pkg::CMD_SAMPLE, -16'sd1, -16'sd15, 16'hFFFF);
      send_item(sdd_pkg::CMD_QUERY, 16'sd0, 16'sd0, '0);
      send_item(sdd_pkg::CMD_SAMPLE, 16'sd1023, 16'sd1023, 16'h0000);
      send_item(sdd_pkg::CMD_QUERY, 16'sd1020, 16'sd1010, '0);
      send_item(sdd_pkg::CMD_SAMPLE, 16'sd312, 16'sd312, 16'd1000);
      send_item(sdd_pkg::CMD_SAMPLE, 16'sd344, 16'sd312, 16'd3000);
      send_item(sdd_pkg::CMD_SAMPLE, 16'sd312, 16'sd344, 16'd5000);
      send_item(sdd_pkg::CMD_QUERY, 16'sd325, 16'sd325, '0);
      send_item(sdd_pkg::CMD_SAMPLE, 16'sd344, 16'sd344, 16'hABCD);
      send_item(sdd_pkg::CMD_QUERY, 16'sd320, 16'sd320, '0);
      send_item(sdd_pkg::CMD_QUERY, 16'sd330, 16'sd310, '0);
      send_item(CMD_UNUSED, 16'sd320, 16'sd320, 16'd7);
      send_item(sdd_pkg::CMD_QUERY, 16'sd344, 16'sd344, '0);
      send_item(sdd_pkg::CMD_CLEAR, '0, '0, '0);
      send_item(sdd_pkg::CMD_QUERY, 16'sd320, 16'sd320, '0);
      send_item(sdd_pkg::CMD_QUERY, 16'sd344, 16'sd344, '0);
   endtask

   // Radius and scale sweeps, extremes included; a radius drop gives
   // negative weights for samples scattered with the wider radius.
   task automatic test_settings();
      write_csr(sdd_pkg::CSR_RADIUS, 8'd7);
      write_csr(sdd_pkg::CSR_SCALE, 8'd255);
      random_items(40);
      write_csr(sdd_pkg::CSR_RADIUS, 8'd1);
      random_items(30);
      write_csr(sdd_pkg::CSR_RADIUS, 8'd0);
      write_csr(sdd_pkg::CSR_SCALE, 8'd0);
      random_items(50);
      write_csr(sdd_pkg::CSR_SCALE, 8'd1);
      random_items(50);
      write_csr(sdd_pkg::CSR_RADIUS, 8'd3);
      write_csr(sdd_pkg::CSR_SCALE, 8'hA5);
   endtask

   task automatic test_idling();
      int rad [4] = '{2, 4, 3, 5};
      int sidle [4] = '{0, 87, 0, 27};
      int rstall [4] = '{0, 0, 87, 27};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = sidle[p];
         recv_stall_pct = rstall[p];
         write_csr(sdd_pkg::CSR_RADIUS, 8'(rad[p]));
         random_items(300);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // Sender holds back until every result is in, then carries on.
   task automatic test_drained_pause();
      random_items(60);
      wait_drained();
      random_items(60);
   endtask

   // Result checking and receiver stalls
   always @(posedge clock) begin
      depth_result_type exp_res;
      rsp_stall <= $urandom_range(99) < recv_stall_pct;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (depth_results.size() == 0) report("result with none expected");
         else begin
            exp_res = depth_results.pop_front();
            if (rsp_depth_out !== exp_res.depth)
               report($sformatf("depth_out %0d, expected %0d", rsp_depth_out,
                                exp_res.depth));
            if (rsp_valid_res !== exp_res.valid)
               report($sformatf("valid_res %0b, expected %0b", rsp_valid_res,
                                exp_res.valid));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      slot_lfsr = sdd_pkg::LFSR_RESET;
      cur_radius = sdd_pkg::RADIUS_RESET;
      cur_scale = sdd_pkg::SCALE_RESET;
      clear_frame();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_settings();
      test_idling();
      test_drained_pause();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
